// ===== hdl/fslf_pkg.sv =====
// Package for the fixed-string line filter: payload structs, register indexes,
// character constants and small helper functions. No dependencies.
package fslf_pkg;

  localparam int MaxPattern = 16;
  localparam int LineBuffer = 8192;
  localparam int PosW = 13;
  localparam int HistDepth = MaxPattern + 1;

  localparam logic [2:0] RegPatLow  = 3'd0;
  localparam logic [2:0] RegPatHigh = 3'd1;
  localparam logic [2:0] RegPatLen  = 3'd2;
  localparam logic [2:0] RegIcase   = 3'd3;
  localparam logic [2:0] RegInvert  = 3'd4;
  localparam logic [2:0] RegWord    = 3'd5;
  localparam logic [2:0] RegLine    = 3'd6;
  localparam logic [2:0] RegMaxSel  = 3'd7;

  localparam logic [7:0] ChNl = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChUs = 8'h5F;
  localparam logic [7:0] ChNul = 8'h00;

  localparam logic KindLine = 1'b0;
  localparam logic KindCount = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic        line_selected;
    logic [31:0] line_number;
    logic [12:0] match_offset;
    logic [31:0] selected_count;
    logic        limit_reached;
    logic        last_result;
  } out_word_t;

  // Classified work passed from front to back.
  typedef struct packed {
    logic            is_eoi;
    logic            close;
    logic            found;
    logic [PosW-1:0] occ_start;
    logic            word_ok;
    logic [PosW-1:0] stripped;
    logic            line_open;
  } job_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    if (ic && c >= 8'h41 && c <= 8'h5A) return c + 8'd32;
    return c;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == ChUs;
  endfunction

endpackage

// ===== hdl/fixed_string_line_filter.sv =====
// Fixed-string line filter, top level: configuration registers, front end,
// job queue and back end. Depends on fslf_pkg and the fslf_* modules.
//
// Usage. Text arrives one word per cycle on in_valid/in_ready: a text byte or
// an end-of-input marker. The block splits text into lines at newlines, or
// after 8191 bytes, strips trailing carriage returns, ignores bytes after a NUL
// and finds the first occurrence of the configured pattern of up to 16 bytes.
// Each finished line gives one decision word on out_valid/out_ready; end of
// input gives the count report, preceded by a decision for an open line.
// Configuration words are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data; the user must write them only while the block is idle, which the
// block itself does not enforce. Throughput is one input word per cycle while
// in_ready is high; the window compare is a combinational set of parallel
// byte comparators. A result word is registered after the word that caused it
// is accepted: the front is combinational, the job is written into the queue
// and the back then loads it into the output register. End of input with an
// open line gives two output words. When the receiver stalls, the queue fills
// and in_ready drops. With a selection limit set, text waits until the queue
// is empty so that the stop flag is settled. Reset (rst_n low at a clock edge)
// clears control state, counters and configuration, not queue or output data.
module fixed_string_line_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fslf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fslf_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  logic [63:0]  pat_lo_r, pat_hi_r;
  logic [127:0] pat_w;
  logic [4:0]   pat_len_r;
  logic         icase_r, inv_r, word_r, line_r;
  logic [31:0]  max_r;
  logic         take, q_full, q_ne, q_pop, stop_now;
  logic [4:0]   eff_len;
  fslf_pkg::job_t fjob, qhead;

  assign cfg_ready = 1'b1;
  assign pat_w = {pat_hi_r, pat_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0; pat_hi_r <= '0; pat_len_r <= '0; icase_r <= 1'b0;
      inv_r <= 1'b0; word_r <= 1'b0; line_r <= 1'b0; max_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        fslf_pkg::RegPatLow:  pat_lo_r <= cfg_data;
        fslf_pkg::RegPatHigh: pat_hi_r <= cfg_data;
        fslf_pkg::RegPatLen:  pat_len_r <= cfg_data[4:0];
        fslf_pkg::RegIcase:   icase_r <= cfg_data[0];
        fslf_pkg::RegInvert:  inv_r <= cfg_data[0];
        fslf_pkg::RegWord:    word_r <= cfg_data[0];
        fslf_pkg::RegLine:    line_r <= cfg_data[0];
        fslf_pkg::RegMaxSel:  max_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // With a limit set, text only moves when the back's stop flag is settled:
  // the queue is empty, so every queued line decision has updated the back's
  // counters. Otherwise a line could be accepted after the limit was reached.
  assign in_ready = !q_full && (in_data.end_of_input || max_r == '0 || !q_ne);
  assign take = in_valid && in_ready;

  fslf_front u_front (
    .clk, .rst_n, .take, .word(in_data), .pat(pat_w),
    .pat_len(pat_len_r), .icase(icase_r), .stopped(stop_now), .job(fjob)
  );

  always_comb begin
    logic done;
    done = 1'b0;
    eff_len = 5'd0;
    for (int i = 0; i < fslf_pkg::MaxPattern; i++) begin
      if (!done && 5'(i) < pat_len_r && pat_w[8*i +: 8] != 8'd0)
        eff_len = 5'(i + 1);
      else done = 1'b1;
    end
  end

  fslf_queue u_queue (
    .clk, .rst_n, .push(take && (fjob.close || fjob.is_eoi)), .push_job(fjob),
    .full(q_full), .pop(q_pop), .nonempty(q_ne), .head(qhead)
  );

  // The back's stop flag is updated as each job is loaded, so it is current
  // as soon as the queue runs empty.
  fslf_back u_back (
    .clk, .rst_n, .job_valid(q_ne), .job(qhead), .job_pop(q_pop),
    .eff_len, .invert(inv_r), .wword(word_r), .wline(line_r), .max_sel(max_r),
    .stopped(stop_now), .out_valid, .out_ready, .out_data
  );

endmodule

// ===== hdl/fslf_front.sv =====
// Front end of the line filter: keeps the per-line scan state, finds the first
// occurrence and emits one job per word. Depends on fslf_pkg.
module fslf_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  fslf_pkg::in_word_t       word,
  input  logic [127:0]             pat,
  input  logic [4:0]               pat_len,
  input  logic                     icase,
  input  logic                     stopped,
  output fslf_pkg::job_t           job
);
  localparam int PW = fslf_pkg::PosW;

  logic [7:0]    hist_r [fslf_pkg::HistDepth];
  logic [7:0]    hist_nxt [fslf_pkg::HistDepth];
  logic [PW-1:0] pos_r, pos_nxt, clen_r, clen_nxt, strip_r, strip_nxt;
  logic [PW-1:0] occ_r, occ_nxt;
  logic          found_r, found_nxt, pend_r, pend_nxt, wok_r, wok_nxt;
  logic          nul_r, nul_nxt, open_r, open_nxt;
  logic [4:0]    eff_len;
  logic          hit;
  logic [7:0]    b;
  logic          content, close;
  logic [PW-1:0] strip_c;

  // Effective pattern length: clamp and stop at the first zero byte.
  always_comb begin
    logic done;
    done = 1'b0;
    eff_len = 5'd0;
    for (int i = 0; i < fslf_pkg::MaxPattern; i++) begin
      if (!done && 5'(i) < pat_len && pat[8*i +: 8] != 8'd0) eff_len = 5'(i + 1);
      else done = 1'b1;
    end
  end

  // hit: pattern of length eff_len ends at the new byte, seen over window.
  always_comb begin
    logic [7:0] win [fslf_pkg::HistDepth];
    logic ok;
    win[0] = word.text_byte;
    for (int i = 1; i < fslf_pkg::HistDepth; i++) win[i] = hist_r[i-1];
    ok = 1'b1;
    for (int i = 0; i < fslf_pkg::MaxPattern; i++)
      if (5'(i) < eff_len &&
          fslf_pkg::fold(pat[8*i +: 8], icase) !=
          fslf_pkg::fold(win[eff_len - 5'(i) - 5'd1], icase)) ok = 1'b0;
    hit = ok;
  end

  assign b = word.text_byte;

  always_comb begin
    logic [PW-1:0] cl;
    cl = clen_r;
    for (int i = 0; i < fslf_pkg::HistDepth; i++) hist_nxt[i] = hist_r[i];
    pos_nxt = pos_r; clen_nxt = clen_r; strip_nxt = strip_r; occ_nxt = occ_r;
    found_nxt = found_r; pend_nxt = pend_r; wok_nxt = wok_r; nul_nxt = nul_r;
    open_nxt = open_r;
    content = 1'b0; close = 1'b0;
    job = '0;
    if (word.end_of_input) begin
      job.is_eoi = 1'b1;
      close = open_r && !stopped;
    end else if (!stopped) begin
      open_nxt = 1'b1;
      pos_nxt = pos_r + 1'b1;
      if (b == fslf_pkg::ChNul) nul_nxt = 1'b1;
      else if (b != fslf_pkg::ChNl && !nul_r) content = 1'b1;
      close = (b == fslf_pkg::ChNl) ||
              ({1'b0, pos_r} + 14'd1 >= 14'(fslf_pkg::LineBuffer - 1));
    end
    if (content) begin
      if (!found_nxt && eff_len == 5'd0) begin
        found_nxt = 1'b1; occ_nxt = clen_r;
        if (clen_r != '0 && fslf_pkg::is_word(hist_r[0])) wok_nxt = 1'b0;
        pend_nxt = 1'b1;
      end
      if (pend_nxt) begin
        if (fslf_pkg::is_word(b)) wok_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
      hist_nxt[0] = b;
      for (int i = 1; i < fslf_pkg::HistDepth; i++) hist_nxt[i] = hist_r[i-1];
      cl = clen_r + 1'b1;
      clen_nxt = cl;
      if (b != fslf_pkg::ChCr) strip_nxt = cl;
      if (!found_nxt && eff_len != 5'd0 && {1'b0, cl} >= {{(PW-4){1'b0}}, eff_len} &&
          hit) begin
        found_nxt = 1'b1; occ_nxt = cl - PW'(eff_len);
        if (occ_nxt != '0 && fslf_pkg::is_word(hist_r[eff_len - 5'd1])) wok_nxt = 1'b0;
        pend_nxt = 1'b1;
      end
    end
    if (close) begin
      if (!found_nxt && eff_len == 5'd0) begin
        found_nxt = 1'b1; occ_nxt = clen_nxt;
        if (clen_nxt != '0 && fslf_pkg::is_word(hist_nxt[0])) wok_nxt = 1'b0;
      end
      strip_c = strip_nxt;
      job.close = 1'b1;
      job.found = found_nxt && ({1'b0, occ_nxt} + 14'(eff_len) <= {1'b0, strip_c});
      job.occ_start = occ_nxt;
      job.word_ok = wok_nxt;
      job.stripped = strip_c;
    end else begin
      strip_c = strip_nxt;
    end
    job.line_open = open_r;
    if (close || word.end_of_input) begin
      for (int i = 0; i < fslf_pkg::HistDepth; i++) hist_nxt[i] = 8'd0;
      pos_nxt = '0; clen_nxt = '0; strip_nxt = '0; occ_nxt = '0; found_nxt = 1'b0;
      pend_nxt = 1'b0; wok_nxt = 1'b1; nul_nxt = 1'b0; open_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fslf_pkg::HistDepth; i++) hist_r[i] <= 8'd0;
      pos_r <= '0; clen_r <= '0; strip_r <= '0; occ_r <= '0; found_r <= 1'b0;
      pend_r <= 1'b0; wok_r <= 1'b1; nul_r <= 1'b0; open_r <= 1'b0;
    end else if (take) begin
      for (int i = 0; i < fslf_pkg::HistDepth; i++) hist_r[i] <= hist_nxt[i];
      pos_r <= pos_nxt; clen_r <= clen_nxt; strip_r <= strip_nxt; occ_r <= occ_nxt;
      found_r <= found_nxt; pend_r <= pend_nxt; wok_r <= wok_nxt; nul_r <= nul_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// ===== hdl/fslf_queue.sv =====
// Two-entry queue of jobs between front and back. Depends on fslf_pkg.
module fslf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fslf_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output fslf_pkg::job_t  head
);
  fslf_pkg::job_t mem_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;

  assign full = cnt_r == 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== hdl/fslf_back.sv =====
// Back end: applies word/line tests and inversion, keeps the counters and
// emits result words into an output register. Depends on fslf_pkg.
module fslf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  input  fslf_pkg::job_t       job,
  output logic                 job_pop,
  input  logic [4:0]           eff_len,
  input  logic                 invert,
  input  logic                 wword,
  input  logic                 wline,
  input  logic [31:0]          max_sel,
  output logic                 stopped,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fslf_pkg::out_word_t  out_data
);
  logic [31:0] lines_r, lines_nxt, hits_r, hits_nxt;
  logic        stop_r, stop_nxt, half_r, half_nxt;
  logic        ov_r;
  fslf_pkg::out_word_t od_r, od_nxt;
  logic        load, m, sel, two;

  assign out_valid = ov_r;
  assign out_data = od_r;
  assign stopped = stop_r;
  assign load = job_valid && (!ov_r || out_ready);
  // End of input with an open line gives two words; half_r marks the first sent.
  assign two = job.is_eoi && job.close;
  assign job_pop = load && (!two || half_r);

  always_comb begin
    lines_nxt = lines_r; hits_nxt = hits_r; stop_nxt = stop_r; half_nxt = half_r;
    od_nxt = '0;
    m = job.found;
    if (wword && !job.word_ok) m = 1'b0;
    if (wline && (job.occ_start != '0 || 13'(eff_len) != job.stripped)) m = 1'b0;
    sel = m ^ invert;
    if (job.close && !half_r) begin
      lines_nxt = lines_r + 32'd1;
      if (sel) begin
        hits_nxt = hits_r + 32'd1;
        if (max_sel != 32'd0 && hits_nxt >= max_sel) stop_nxt = 1'b1;
      end
      od_nxt.result_kind = fslf_pkg::KindLine;
      od_nxt.line_selected = sel;
      od_nxt.line_number = lines_nxt;
      od_nxt.match_offset = job.found ? job.occ_start : '0;
      od_nxt.selected_count = hits_nxt;
      od_nxt.limit_reached = stop_nxt;
      od_nxt.last_result = !job.is_eoi;
      half_nxt = two;
    end else begin
      od_nxt.result_kind = fslf_pkg::KindCount;
      od_nxt.line_number = lines_r;
      od_nxt.selected_count = hits_r;
      od_nxt.limit_reached = stop_r;
      od_nxt.last_result = 1'b1;
      lines_nxt = '0; hits_nxt = '0; stop_nxt = 1'b0; half_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) od_r <= od_nxt;
    if (!rst_n) begin
      ov_r <= 1'b0; lines_r <= '0; hits_r <= '0; stop_r <= 1'b0; half_r <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
        lines_r <= lines_nxt; hits_r <= hits_nxt; stop_r <= stop_nxt;
        half_r <= half_nxt;
      end else if (out_ready) ov_r <= 1'b0;
    end
  end

  // stop_r is read by the front through the top level.
endmodule

// ===== hdl/fslf_checker.sv =====
// Port-level checker for the line filter, bound to the top level.
// Depends on fslf_pkg.
module fslf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fslf_pkg::out_word_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");
  a_count_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == fslf_pkg::KindCount |-> out_data.last_result)
    else $error("count report not marked last");
  a_count_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == fslf_pkg::KindCount |->
    !out_data.line_selected && out_data.match_offset == '0)
    else $error("count report carries line fields");
  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.limit_reached |-> out_data.selected_count != '0)
    else $error("limit flag set with no selected lines");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("input word withdrawn before acceptance");
endmodule

bind fixed_string_line_filter fslf_checker u_fslf_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
